### rtl/pcfw_pkg.sv
package pcfw_pkg;

    // Frame length in bits; the packed fields fill the first 23, the rest are zero.
    localparam int FRAME_BITS  = 25;
    localparam int FIELD_BITS  = 23;
    localparam int BITS_LEFT_W = $clog2(FRAME_BITS + 1);
    localparam int TICK_W      = 16;
    localparam int CFG_IDX_W   = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_PHASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PHASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_HOLD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_GAP    = 2'd3;

    localparam logic [TICK_W-1:0] LOW_PHASE_RST  = 16'd9;
    localparam logic [TICK_W-1:0] HIGH_PHASE_RST = 16'd9;
    localparam logic [TICK_W-1:0] DATA_HOLD_RST  = 16'd200;
    localparam logic [TICK_W-1:0] END_GAP_RST    = 16'd1200;

    // Request opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LOW  = 2'd1,
        PH_HIGH = 2'd2,
        PH_DATA = 2'd3
    } t_phase;

    typedef struct packed {
        logic       op;
        logic [7:0] sensitivity;
        logic [7:0] blind_seconds;
        logic [7:0] pulse_count;
        logic [7:0] window_seconds;
        logic       motion_enable;
        logic       interrupt_source;
        logic [1:0] adc_source;
        logic       regulator_enable;
        logic       self_test;
        logic       sample_capacitor;
    } t_in_req;

    typedef struct packed {
        logic serial_line;
        logic busy_res;
        logic frame_done;
        logic start_refused;
    } t_out_res;

    typedef struct packed {
        logic [TICK_W-1:0] low_phase_ticks;
        logic [TICK_W-1:0] high_phase_ticks;
        logic [TICK_W-1:0] data_hold_ticks;
        logic [TICK_W-1:0] end_gap_ticks;
    } t_cfg;

    // A tick count of zero acts as one
    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

endpackage

### rtl/pcfw_frame_build.sv
module pcfw_frame_build (
    input  pcfw_pkg::t_in_req                 i_req,
    output logic [pcfw_pkg::FRAME_BITS-1:0]   o_frame
);

    logic [17:0] blind_prod;
    logic [5:0]  blind_q;
    logic [3:0]  blind_code;
    logic [1:0]  pulse_code;
    logic [5:0]  win_q;
    logic [1:0]  win_code;
    logic [pcfw_pkg::FIELD_BITS-1:0] fields;

    always_comb begin
        // seconds / 5 by reciprocal: exact for 8-bit inputs
        blind_prod = 18'(i_req.blind_seconds) * 18'd205;
        blind_q    = blind_prod[15:10];
        if (blind_q == 6'd0) begin
            blind_code = 4'd0;
        end else if (blind_q > 6'd16) begin
            blind_code = 4'd15;
        end else begin
            blind_code = 4'(blind_q - 6'd1);
        end

        if (i_req.pulse_count == 8'd0) begin
            pulse_code = 2'd0;
        end else if (i_req.pulse_count > 8'd4) begin
            pulse_code = 2'd3;
        end else begin
            pulse_code = 2'(i_req.pulse_count - 8'd1);
        end

        win_q = i_req.window_seconds[7:2];
        if (win_q == 6'd0) begin
            win_code = 2'd0;
        end else if (win_q > 6'd4) begin
            win_code = 2'd3;
        end else begin
            win_code = 2'(win_q - 6'd1);
        end

        fields = {i_req.sensitivity, blind_code, pulse_code, win_code,
                  i_req.motion_enable, i_req.interrupt_source, i_req.adc_source,
                  i_req.regulator_enable, i_req.self_test, i_req.sample_capacitor};
    end

    // First field bit lands in the msb, zero padding below
    assign o_frame = {fields, (pcfw_pkg::FRAME_BITS - pcfw_pkg::FIELD_BITS)'(0)};

endmodule

### rtl/pcfw_sequencer.sv
module pcfw_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  pcfw_pkg::t_in_req                i_req,
    input  logic [pcfw_pkg::FRAME_BITS-1:0]  i_frame,
    input  pcfw_pkg::t_cfg                   i_cfg,
    output pcfw_pkg::t_out_res               o_res
);

    pcfw_pkg::t_phase                       r_phase,     n_phase;
    logic [pcfw_pkg::FRAME_BITS-1:0]        r_shift,     n_shift;
    logic [pcfw_pkg::BITS_LEFT_W-1:0]       r_bits_left, n_bits_left;
    logic [pcfw_pkg::TICK_W-1:0]            r_timer,     n_timer;

    logic                                   cur_level;
    logic [pcfw_pkg::TICK_W-1:0]            timer_dec;
    logic [pcfw_pkg::BITS_LEFT_W-1:0]       bits_dec;

    always_comb begin
        unique case (r_phase)
            pcfw_pkg::PH_HIGH: cur_level = 1'b1;
            pcfw_pkg::PH_DATA: cur_level = r_shift[pcfw_pkg::FRAME_BITS-1];
            default:           cur_level = 1'b0;
        endcase
        timer_dec = (r_timer != '0) ? r_timer - pcfw_pkg::TICK_W'(1) : r_timer;
        bits_dec  = (r_bits_left != '0) ? r_bits_left - pcfw_pkg::BITS_LEFT_W'(1)
                                        : r_bits_left;
    end

    // Next state
    always_comb begin
        n_phase     = r_phase;
        n_shift     = r_shift;
        n_bits_left = r_bits_left;
        n_timer     = r_timer;
        if (i_req.op == pcfw_pkg::OP_START) begin
            if (r_phase == pcfw_pkg::PH_IDLE) begin
                n_shift     = i_frame;
                n_bits_left = pcfw_pkg::BITS_LEFT_W'(pcfw_pkg::FRAME_BITS);
                n_phase     = pcfw_pkg::PH_LOW;
                n_timer     = pcfw_pkg::at_least_one(i_cfg.low_phase_ticks);
            end
        end else if (r_phase != pcfw_pkg::PH_IDLE) begin
            n_timer = timer_dec;
            if (timer_dec == '0) begin
                unique case (r_phase)
                    pcfw_pkg::PH_LOW: begin
                        if (r_bits_left == '0) begin
                            n_phase = pcfw_pkg::PH_IDLE;
                            n_shift = '0;
                        end else begin
                            n_phase = pcfw_pkg::PH_HIGH;
                            n_timer = pcfw_pkg::at_least_one(i_cfg.high_phase_ticks);
                        end
                    end
                    pcfw_pkg::PH_HIGH: begin
                        n_phase = pcfw_pkg::PH_DATA;
                        n_timer = pcfw_pkg::at_least_one(i_cfg.data_hold_ticks);
                    end
                    default: begin
                        n_shift     = r_shift << 1;
                        n_bits_left = bits_dec;
                        n_phase     = pcfw_pkg::PH_LOW;
                        n_timer     = (bits_dec != '0)
                                    ? pcfw_pkg::at_least_one(i_cfg.low_phase_ticks)
                                    : pcfw_pkg::at_least_one(i_cfg.end_gap_ticks);
                    end
                endcase
            end
        end
    end

    // Result for the request in flight
    always_comb begin
        o_res = '0;
        if (r_phase != pcfw_pkg::PH_IDLE) begin
            o_res.serial_line = cur_level;
        end
        if (i_req.op == pcfw_pkg::OP_START) begin
            o_res.start_refused = (r_phase != pcfw_pkg::PH_IDLE);
        end else begin
            o_res.frame_done = (r_phase == pcfw_pkg::PH_LOW) && (r_bits_left == '0)
                             && (timer_dec == '0);
        end
        o_res.busy_res = (n_phase != pcfw_pkg::PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= pcfw_pkg::PH_IDLE;
            r_shift     <= '0;
            r_bits_left <= '0;
            r_timer     <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_shift     <= n_shift;
            r_bits_left <= n_bits_left;
            r_timer     <= n_timer;
        end
    end

endmodule

### rtl/pir_config_frame_serial_writer.sv
// Channel | Direction | Handshake                    | Payload
// --------+-----------+------------------------------+---------------------
// in      | input     | i_in_valid / o_in_stall      | i_in_data  (t_in_req)
// out     | output    | o_out_valid / i_out_stall    | o_out_data (t_out_res)
// cfg     | input     | i_cfg_we (no handshake back) | i_cfg_index, i_cfg_data
//
// One request per cycle sustained while the output is not stalled; an accepted request
// waits in the input register and its result is then loaded into the result register,
// from which it is taken (input register, then result register).
// All per-request work (frame packing, phase timer, bit shifter) sits between
// those two registers. Reset is synchronous, active low, and returns the
// sequencer to idle with the tick registers at their defaults. A stall on the
// output holds the result register and backs up into the input register.
module pir_config_frame_serial_writer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  pcfw_pkg::t_in_req                 i_in_data,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output pcfw_pkg::t_out_res                o_out_data,

    input  logic                              i_cfg_we,
    input  logic [pcfw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pcfw_pkg::TICK_W-1:0]       i_cfg_data
);

    logic                               r_in_valid;
    pcfw_pkg::t_in_req                  r_in_req;
    logic                               r_out_valid;
    pcfw_pkg::t_out_res                 r_out_res;
    pcfw_pkg::t_cfg                     r_cfg;

    logic                               advance;
    logic [pcfw_pkg::FRAME_BITS-1:0]    frame;
    pcfw_pkg::t_out_res                 step_res;

    // Advance the held request when the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    // Input register: load whenever its content moves on or it is empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_req <= i_in_data;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_phase_ticks  <= pcfw_pkg::LOW_PHASE_RST;
            r_cfg.high_phase_ticks <= pcfw_pkg::HIGH_PHASE_RST;
            r_cfg.data_hold_ticks  <= pcfw_pkg::DATA_HOLD_RST;
            r_cfg.end_gap_ticks    <= pcfw_pkg::END_GAP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pcfw_pkg::CFG_LOW_PHASE:  r_cfg.low_phase_ticks  <= i_cfg_data;
                pcfw_pkg::CFG_HIGH_PHASE: r_cfg.high_phase_ticks <= i_cfg_data;
                pcfw_pkg::CFG_DATA_HOLD:  r_cfg.data_hold_ticks  <= i_cfg_data;
                pcfw_pkg::CFG_END_GAP:    r_cfg.end_gap_ticks    <= i_cfg_data;
                default:                  r_cfg.end_gap_ticks    <= r_cfg.end_gap_ticks;
            endcase
        end
    end

    // Pack the frame codes from the held start request
    pcfw_frame_build u_frame_build (
        .i_req   (r_in_req),
        .o_frame (frame)
    );

    // Phase sequencer: commits state only when the request advances
    pcfw_sequencer u_sequencer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_req   (r_in_req),
        .i_frame (frame),
        .i_cfg   (r_cfg),
        .o_res   (step_res)
    );

    // Result register: hold while stalled, drop when taken with nothing behind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_res <= step_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_res;

endmodule
